/* src/scb_pkg.sv */
package scb_pkg;

    localparam int DIV_STEPS = 17;
    localparam int NSTAGE    = 3 + DIV_STEPS + 2;
    localparam int TW        = 20;

    localparam logic signed [TW-1:0] TIME_ONE   = 20'sd32768;
    localparam logic signed [TW-1:0] TIME_FLOOR = -20'sd524288;
    localparam logic signed [TW-1:0] TIME_CEIL  = 20'sd524287;
    localparam logic signed [TW-1:0] OVF_POS    = 20'sd131072;
    localparam logic signed [TW-1:0] OVF_NEG    = -20'sd131073;

    localparam logic signed [1:0] NORM_POS  = 2'sb01;
    localparam logic signed [1:0] NORM_NEG  = 2'sb11;
    localparam logic signed [1:0] NORM_ZERO = 2'sb00;

    localparam int AX_X_ENT = 0;
    localparam int AX_X_EXT = 1;
    localparam int AX_Y_ENT = 2;
    localparam int AX_Y_EXT = 3;

    typedef struct packed {
        logic signed [15:0] mover_x;
        logic signed [15:0] mover_y;
        logic [14:0]        mover_w;
        logic [14:0]        mover_h;
        logic signed [15:0] mover_vx;
        logic signed [15:0] mover_vy;
        logic signed [15:0] block_x;
        logic signed [15:0] block_y;
        logic [14:0]        block_w;
        logic [14:0]        block_h;
        logic [15:0]        frame_time;
    } box_pair_t;

    typedef struct packed {
        logic [30:0] rem;
        logic [30:0] den;
        logic [16:0] quo;
        logic        neg;
        logic        ovf;
        logic        still;
        logic        dneg;
    } div_t;

    typedef struct packed {
        logic               hit;
        logic [15:0]        contact_time;
        logic signed [1:0]  normal_x;
        logic signed [1:0]  normal_y;
    } res_t;

endpackage

/* src/scb_front.sv */
module scb_front (
    input  logic                   aclk,
    input  logic [2:0]             en,
    input  scb_pkg::box_pair_t     pair,
    output scb_pkg::div_t [3:0]    div_out
);

    scb_pkg::box_pair_t in_reg;

    logic signed [17:0] dist_reg [4];
    logic signed [17:0] dist_next [4];
    logic signed [31:0] disp_x_reg, disp_y_reg;
    logic signed [31:0] disp_x_next, disp_y_next;
    scb_pkg::div_t [3:0] div_reg, div_next;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            in_reg <= pair;
        end
    end

    always_comb begin
        logic signed [17:0] mx, my, mw, mh, bx, by, bw, bh;
        logic signed [17:0] x_right, x_left, y_down, y_up;
        logic signed [16:0] fts;
        logic signed [32:0] px, py;
        logic               vx_pos, vy_pos;
        mx = 18'(in_reg.mover_x);
        my = 18'(in_reg.mover_y);
        mw = signed'({3'b000, in_reg.mover_w});
        mh = signed'({3'b000, in_reg.mover_h});
        bx = 18'(in_reg.block_x);
        by = 18'(in_reg.block_y);
        bw = signed'({3'b000, in_reg.block_w});
        bh = signed'({3'b000, in_reg.block_h});
        x_right = (bx + bw) - mx;
        x_left  = bx - (mx + mw);
        y_down  = (by + bh) - my;
        y_up    = by - (my + mh);
        vx_pos  = !in_reg.mover_vx[15] && (in_reg.mover_vx != 16'sd0);
        vy_pos  = !in_reg.mover_vy[15] && (in_reg.mover_vy != 16'sd0);
        dist_next[scb_pkg::AX_X_ENT] = vx_pos ? x_left : x_right;
        dist_next[scb_pkg::AX_X_EXT] = vx_pos ? x_right : x_left;
        dist_next[scb_pkg::AX_Y_ENT] = vy_pos ? y_up : y_down;
        dist_next[scb_pkg::AX_Y_EXT] = vy_pos ? y_down : y_up;
        fts = signed'({1'b0, in_reg.frame_time});
        px  = 33'(in_reg.mover_vx) * 33'(fts);
        py  = 33'(in_reg.mover_vy) * 33'(fts);
        disp_x_next = px[31:0];
        disp_y_next = py[31:0];
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            dist_reg   <= dist_next;
            disp_x_reg <= disp_x_next;
            disp_y_reg <= disp_y_next;
        end
    end

    always_comb begin
        logic signed [31:0] disp;
        logic [31:0]        dabs;
        logic [17:0]        nabs;
        logic [30:0]        start;
        for (int i = 0; i < 4; i++) begin
            disp  = (i < 2) ? disp_x_reg : disp_y_reg;
            dabs  = disp[31] ? 32'(-disp) : 32'(disp);
            nabs  = dist_reg[i][17] ? 18'(-dist_reg[i]) : 18'(dist_reg[i]);
            start = {nabs[16:0], 14'b0};
            div_next[i].dneg  = dist_reg[i][17];
            div_next[i].neg   = dist_reg[i][17] ^ disp[31];
            div_next[i].still = (disp == 32'sd0);
            div_next[i].den   = dabs[30:0];
            div_next[i].ovf   = (disp != 32'sd0) && (start >= dabs[30:0]);
            div_next[i].rem   = div_next[i].ovf ? 31'd0 : start;
            div_next[i].quo   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            div_reg <= div_next;
        end
    end

    assign div_out = div_reg;

endmodule

/* src/scb_divider.sv */
module scb_divider (
    input  logic                            aclk,
    input  logic [scb_pkg::DIV_STEPS-1:0]   en,
    input  scb_pkg::div_t                   div_in,
    output scb_pkg::div_t                   div_out
);

    scb_pkg::div_t st_reg [scb_pkg::DIV_STEPS];
    scb_pkg::div_t st_next [scb_pkg::DIV_STEPS];

    function automatic scb_pkg::div_t div_step(scb_pkg::div_t d);
        scb_pkg::div_t r;
        logic [31:0]   r2;
        logic [31:0]   diff;
        logic          take;
        r    = d;
        r2   = {d.rem, 1'b0};
        diff = r2 - {1'b0, d.den};
        take = (r2 >= {1'b0, d.den});
        r.rem = take ? diff[30:0] : r2[30:0];
        r.quo = {d.quo[15:0], take};
        return r;
    endfunction

    always_comb begin
        st_next[0] = div_step(div_in);
        for (int i = 1; i < scb_pkg::DIV_STEPS; i++) begin
            st_next[i] = div_step(st_reg[i-1]);
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < scb_pkg::DIV_STEPS; i++) begin
            if (en[i]) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign div_out = st_reg[scb_pkg::DIV_STEPS-1];

endmodule

/* src/scb_resolve.sv */
module scb_resolve (
    input  logic                  aclk,
    input  logic [1:0]            en,
    input  scb_pkg::div_t [3:0]   div_in,
    output scb_pkg::res_t         res
);

    logic signed [scb_pkg::TW-1:0] t_reg [4];
    logic signed [scb_pkg::TW-1:0] t_next [4];
    logic xneg_reg, yneg_reg;
    scb_pkg::res_t res_reg, res_next;

    function automatic logic signed [scb_pkg::TW-1:0] time_of(scb_pkg::div_t d,
                                                             logic is_exit);
        logic [scb_pkg::TW-1:0] mag;
        logic signed [scb_pkg::TW-1:0] t;
        mag = {3'b000, d.quo} + {19'd0, (d.neg && d.rem != 31'd0)};
        if (d.still) begin
            t = is_exit ? scb_pkg::TIME_CEIL : scb_pkg::TIME_FLOOR;
        end else if (d.ovf) begin
            t = d.neg ? scb_pkg::OVF_NEG : scb_pkg::OVF_POS;
        end else begin
            t = d.neg ? -signed'(mag) : signed'(mag);
        end
        return t;
    endfunction

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            t_next[i] = time_of(div_in[i], (i == scb_pkg::AX_X_EXT) ||
                                           (i == scb_pkg::AX_Y_EXT));
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            t_reg    <= t_next;
            xneg_reg <= div_in[scb_pkg::AX_X_ENT].dneg;
            yneg_reg <= div_in[scb_pkg::AX_Y_ENT].dneg;
        end
    end

    always_comb begin
        logic signed [scb_pkg::TW-1:0] tx_ent, tx_ext, ty_ent, ty_ext, t_ent, t_ext;
        logic x_wins, miss;
        tx_ent = t_reg[scb_pkg::AX_X_ENT];
        tx_ext = t_reg[scb_pkg::AX_X_EXT];
        ty_ent = t_reg[scb_pkg::AX_Y_ENT];
        ty_ext = t_reg[scb_pkg::AX_Y_EXT];
        x_wins = tx_ent > ty_ent;
        t_ent  = x_wins ? tx_ent : ty_ent;
        t_ext  = (tx_ext < ty_ext) ? tx_ext : ty_ext;
        miss   = (t_ent > t_ext) || (tx_ent[scb_pkg::TW-1] && ty_ent[scb_pkg::TW-1]) ||
                 (tx_ent > scb_pkg::TIME_ONE) || (ty_ent > scb_pkg::TIME_ONE);
        res_next.hit = !miss;
        if (miss) begin
            res_next.contact_time = 16'(scb_pkg::TIME_ONE);
            res_next.normal_x     = scb_pkg::NORM_ZERO;
            res_next.normal_y     = scb_pkg::NORM_ZERO;
        end else begin
            res_next.contact_time = t_ent[15:0];
            res_next.normal_x     = !x_wins ? scb_pkg::NORM_ZERO :
                                    (xneg_reg ? scb_pkg::NORM_POS : scb_pkg::NORM_NEG);
            res_next.normal_y     = x_wins ? scb_pkg::NORM_ZERO :
                                    (yneg_reg ? scb_pkg::NORM_POS : scb_pkg::NORM_NEG);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

/* src/swept_box_collision_unit.sv */
// Each input word passes the front, divider and resolve stages in order.
// Throughput: one word per cycle unless m_tready holds the output; a 17-stage
// restoring divider per axis time, one quotient bit per stage, sets the depth.
// Each stage advances when the next one is empty or moving, so bubbles close up.
// Reset (aresetn low, synchronous) clears all stage valid bits; data is not reset.
module swept_box_collision_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mover_x, mover_y, mover_w, mover_h, mover_vx, mover_vy,
    // block_x, block_y, block_w, block_h, frame_time, 4 pad bits
    input  logic [175:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit, contact_time, normal_x, normal_y, 3 pad bits
    output logic [23:0]  m_tdata
);

    localparam int NS = scb_pkg::NSTAGE;

    logic [NS-1:0] valid_reg, valid_next;
    logic [NS-1:0] en;
    scb_pkg::box_pair_t  pair;
    scb_pkg::div_t [3:0] div_a, div_b;
    scb_pkg::res_t       res;

    always_comb begin
        en[NS-1] = !valid_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        valid_next = valid_reg;
        if (en[0]) begin
            valid_next[0] = s_tvalid;
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[NS-1];

    assign pair.mover_x    = s_tdata[15:0];
    assign pair.mover_y    = s_tdata[31:16];
    assign pair.mover_w    = s_tdata[46:32];
    assign pair.mover_h    = s_tdata[61:47];
    assign pair.mover_vx   = s_tdata[77:62];
    assign pair.mover_vy   = s_tdata[93:78];
    assign pair.block_x    = s_tdata[109:94];
    assign pair.block_y    = s_tdata[125:110];
    assign pair.block_w    = s_tdata[140:126];
    assign pair.block_h    = s_tdata[155:141];
    assign pair.frame_time = s_tdata[171:156];

    scb_front u_front (
        .aclk    (aclk),
        .en      (en[2:0]),
        .pair    (pair),
        .div_out (div_a)
    );

    for (genvar g = 0; g < 4; g++) begin : g_div
        scb_divider u_div (
            .aclk    (aclk),
            .en      (en[3 + scb_pkg::DIV_STEPS - 1:3]),
            .div_in  (div_a[g]),
            .div_out (div_b[g])
        );
    end

    scb_resolve u_resolve (
        .aclk   (aclk),
        .en     (en[NS-1:NS-2]),
        .div_in (div_b),
        .res    (res)
    );

    assign m_tdata = {3'b000, res.normal_y, res.normal_x, res.contact_time, res.hit};

`ifndef NO_ASSERTIONS
    a_miss_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[16:1] == 16'd32768 && m_tdata[20:17] == 4'd0)
        else $error("miss word carries wrong time or normal");

    a_hit_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> (m_tdata[18:17] != 2'b00) != (m_tdata[20:19] != 2'b00))
        else $error("hit word needs exactly one normal axis");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> valid_reg[0] && m_tvalid && !m_tready)
        else $error("input stalled while a stage is free");
`endif

endmodule

/* dv/swept_box_checker.sv */
module swept_box_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [175:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [23:0]  m_tdata,
    output int           fail_count,
    output int           pending_count
);

    localparam longint TIME_UNIT = 32768;
    localparam longint UNBOUNDED = 64'sd1 <<< 62;

    typedef struct {
        logic              hit;
        logic [15:0]       contact_time;
        logic signed [1:0] normal_x;
        logic signed [1:0] normal_y;
    } contact_t;

    contact_t contact_q[$];

    function automatic longint div_floor(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d != 0) && ((n < 0) != (d < 0)))
            q = q - 1;
        return q;
    endfunction

    function automatic contact_t sweep_contact(logic [175:0] w);
        longint mx, my, mw, mh, vx, vy, bx, by, bw, bh, ft;
        longint xe, xx, ye, yx, dx, dy, txe, txx, tye, tyx, te, tx;
        contact_t c;
        mx = longint'($signed(w[15:0]));
        my = longint'($signed(w[31:16]));
        mw = longint'(w[46:32]);
        mh = longint'(w[61:47]);
        vx = longint'($signed(w[77:62]));
        vy = longint'($signed(w[93:78]));
        bx = longint'($signed(w[109:94]));
        by = longint'($signed(w[125:110]));
        bw = longint'(w[140:126]);
        bh = longint'(w[155:141]);
        ft = longint'(w[171:156]);
        xe = vx > 0 ? bx - (mx + mw) : (bx + bw) - mx;
        xx = vx > 0 ? (bx + bw) - mx : bx - (mx + mw);
        ye = vy > 0 ? by - (my + mh) : (by + bh) - my;
        yx = vy > 0 ? (by + bh) - my : by - (my + mh);
        dx = vx * ft;
        dy = vy * ft;
        txe = dx == 0 ? -UNBOUNDED : div_floor(xe * (64'sd1 <<< 31), dx);
        txx = dx == 0 ? UNBOUNDED : div_floor(xx * (64'sd1 <<< 31), dx);
        tye = dy == 0 ? -UNBOUNDED : div_floor(ye * (64'sd1 <<< 31), dy);
        tyx = dy == 0 ? UNBOUNDED : div_floor(yx * (64'sd1 <<< 31), dy);
        te = txe > tye ? txe : tye;
        tx = txx < tyx ? txx : tyx;
        c.normal_x = 2'sd0;
        c.normal_y = 2'sd0;
        if (te > tx || (txe < 0 && tye < 0) || txe > TIME_UNIT || tye > TIME_UNIT) begin
            c.hit = 1'b0;
            c.contact_time = 16'(TIME_UNIT);
        end else begin
            c.hit = 1'b1;
            c.contact_time = te[15:0];
            if (txe > tye)
                c.normal_x = xe < 0 ? 2'sd1 : -2'sd1;
            else
                c.normal_y = ye < 0 ? 2'sd1 : -2'sd1;
        end
        return c;
    endfunction

    always_ff @(posedge aclk) begin
        contact_t e;
        int       errs;
        errs = 0;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                contact_q.push_back(sweep_contact(s_tdata));
            if (m_tvalid && m_tready) begin
                if (contact_q.size() == 0) begin
                    $error("unexpected result word %h", m_tdata);
                    errs = errs + 1;
                end else begin
                    e = contact_q.pop_front();
                    if (m_tdata[0] !== e.hit) begin
                        $error("hit: expected %0d, got %0d", e.hit, m_tdata[0]);
                        errs = errs + 1;
                    end
                    if (m_tdata[16:1] !== e.contact_time) begin
                        $error("contact_time: expected %0d, got %0d", e.contact_time,
                               m_tdata[16:1]);
                        errs = errs + 1;
                    end
                    if (m_tdata[18:17] !== e.normal_x) begin
                        $error("normal_x: expected %0d, got %0d", e.normal_x,
                               $signed(m_tdata[18:17]));
                        errs = errs + 1;
                    end
                    if (m_tdata[20:19] !== e.normal_y) begin
                        $error("normal_y: expected %0d, got %0d", e.normal_y,
                               $signed(m_tdata[20:19]));
                        errs = errs + 1;
                    end
                end
            end
        end
        fail_count <= fail_count + errs;
        pending_count <= contact_q.size();
    end

endmodule

/* dv/tb_top.sv */
module tb_top;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [175:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [23:0]  m_tdata;
    int           fail_count;
    int           pending_count;
    longint       cycle_count = 0;
    bit           stim_done = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    swept_box_collision_unit i_dut (.*);

    swept_box_checker i_checker (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge aclk) begin
        int g;
        if (!aresetn || stim_done) begin
            m_tready <= 1'b1;
        end else begin
            g = gap_length();
            if (g == 0)
                m_tready <= 1'b1;
            else begin
                m_tready <= 1'b0;
                repeat (g) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [175:0] pack_pair(logic [15:0] mx, logic [15:0] my,
            logic [14:0] mw, logic [14:0] mh, logic [15:0] vx, logic [15:0] vy,
            logic [15:0] bx, logic [15:0] by, logic [14:0] bw, logic [14:0] bh,
            logic [15:0] ft);
        return {4'b0, ft, bh, bw, by, bx, vy, vx, mh, mw, my, mx};
    endfunction

    function automatic logic [15:0] small_signed();
        return 16'($signed($urandom_range(0, 1600)) - 800);
    endfunction

    function automatic logic [175:0] random_pair();
        int k;
        k = $urandom_range(0, 9);
        if (k < 3)
            return {4'b0, 172'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom})};
        return pack_pair(small_signed(), small_signed(), 15'($urandom_range(0, 400)),
                         15'($urandom_range(0, 400)),
                         k == 3 ? 16'h0 : 16'($urandom), k == 4 ? 16'h0 : 16'($urandom),
                         small_signed(), small_signed(), 15'($urandom_range(0, 400)),
                         15'($urandom_range(0, 400)),
                         k == 5 ? 16'h0 : 16'($urandom));
    endfunction

    task automatic send_word(logic [175:0] w);
        int g;
        g = gap_length();
        if (g != 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tdata <= w;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    initial begin
        logic [175:0] directed[$];
        directed.push_back(pack_pair(16'd0, 16'd0, 15'd160, 15'd160, 16'd1600, 16'd0,
                                     16'd320, 16'd0, 15'd160, 15'd160, 16'hffff));
        directed.push_back(pack_pair(16'd320, 16'd0, 15'd160, 15'd160, -16'sd1600, 16'd0,
                                     16'd0, 16'd0, 15'd160, 15'd160, 16'hffff));
        directed.push_back(pack_pair(16'd0, 16'd0, 15'd160, 15'd160, 16'd0, 16'd1600,
                                     16'd0, 16'd320, 15'd160, 15'd160, 16'hffff));
        directed.push_back(pack_pair(16'd0, 16'd320, 15'd160, 15'd160, 16'd0, -16'sd1600,
                                     16'd0, 16'd0, 15'd160, 15'd160, 16'hffff));
        directed.push_back(pack_pair(16'd0, 16'd0, 15'd160, 15'd160, 16'd1600, 16'd1600,
                                     16'd0, 16'd0, 15'd160, 15'd160, 16'd0));
        directed.push_back(pack_pair(16'd0, 16'd0, 15'd0, 15'd0, 16'd0, 16'd0,
                                     16'd0, 16'd0, 15'd0, 15'd0, 16'd0));
        directed.push_back(pack_pair(16'h8000, 16'h8000, 15'h7fff, 15'h7fff, 16'h7fff,
                                     16'h7fff, 16'h7fff, 16'h7fff, 15'h7fff, 15'h7fff,
                                     16'hffff));
        directed.push_back(pack_pair(16'h7fff, 16'h7fff, 15'h7fff, 15'h7fff, 16'h8000,
                                     16'h8000, 16'h8000, 16'h8000, 15'h7fff, 15'h7fff,
                                     16'd1));
        directed.push_back(pack_pair(16'd0, 16'd0, 15'd16, 15'd16, 16'd1, -16'sd1,
                                     16'd32, 16'hffe0, 15'd16, 15'd16, 16'd1));
        directed.push_back(pack_pair(16'd0, 16'd0, 15'd160, 15'd160, 16'd1600, 16'd1600,
                                     16'd320, 16'd320, 15'd160, 15'd160, 16'h8000));
        directed.push_back(pack_pair(16'd0, 16'd0, 15'd160, 15'd160, 16'd32, 16'd32,
                                     16'd3200, 16'd0, 15'd160, 15'd160, 16'hffff));
        directed.push_back(pack_pair(16'd0, 16'd0, 15'd160, 15'd160, 16'd1600, 16'd0,
                                     16'd80, 16'd80, 15'd160, 15'd160, 16'hffff));
        directed.push_back(pack_pair(16'd0, 16'd0, 15'd160, 15'd160, -16'sd1600, 16'd1600,
                                     16'd320, 16'd0, 15'd160, 15'd160, 16'hffff));
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed[i])
            send_word(directed[i]);
        for (int n = 0; n < 1000; n++) begin
            if (n == 500) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending_count != 0) @(posedge aclk);
            end
            send_word(random_pair());
        end
        s_tvalid <= 1'b0;
        stim_done <= 1'b1;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
